### hw/rtl/csc_pkg.sv
// Shared types, character codes and helpers for the comment style converter.
package csc_pkg;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam int MAX_BYTES = 4;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_SLASH  = 3'd1,
		MODE_QUOTE  = 3'd2,
		MODE_BLOCK  = 3'd3,
		MODE_STAR   = 3'd4,
		MODE_LINE   = 3'd5,
		MODE_BSLASH = 3'd6
	} mode_t;

	// One command: up to four output bytes produced by one input byte.
	typedef struct packed {
		logic [2:0]                 cnt;
		logic [MAX_BYTES-1:0][7:0] bytes;
	} cmd_t;

	function automatic cmd_t push_byte(cmd_t c, logic [7:0] b);
		cmd_t r;
		r = c;
		r.bytes[c.cnt[1:0]] = b;
		r.cnt = c.cnt + 3'd1;
		return r;
	endfunction

endpackage

### hw/rtl/comment_style_converter_unit.sv
// Top level of the comment style converter: front end, command queue, back end.
// Converts block comments in a byte stream to line comments.
// Input: s_axis_* carries one source byte per transfer. Output: m_axis_* carries
// the converted bytes; m_axis_tlast marks the final byte produced for one input
// byte. An input byte that produces nothing (a held slash, comment openers, a
// star that may close a block) yields no output transfer.
// The command for an input byte is registered in the queue before its first
// output byte appears. Throughput: one input byte per cycle while the command
// queue has room; the output side sends one byte per cycle while the receiver
// is ready, so an input byte that expands to N bytes (at most four) takes N
// output transfers. The queue of DEPTH commands absorbs those bursts; when it
// fills, s_axis_tready drops until the back end frees an entry.
// When the receiver stalls, the current byte holds on m_axis and the queue keeps
// taking input until full. Reset returns to normal-text mode with no prefix
// pending and empties the queue; a slash held at end of stream is dropped.
module comment_style_converter_unit #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast    // last_of_run
);

	csc_pkg::cmd_t new_cmd, head_cmd;
	logic          push, pop, full, not_empty;

	assign s_axis_tready = !full;

	csc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.push     (push),
		.cmd      (new_cmd)
	);

	csc_queue #(.DEPTH(DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (new_cmd),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head_cmd)
	);

	csc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (not_empty),
		.head       (head_cmd),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_data   (m_axis_tdata),
		.out_last   (m_axis_tlast),
		.pop        (pop)
	);

	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (head_cmd.cnt != 3'd0 && head_cmd.cnt <= 3'd4))
		else $error("queued command has no bytes or too many");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command pushed into a full queue");

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (m_axis_tlast && m_axis_tvalid))
		else $error("command retired before its last byte");

endmodule

### hw/rtl/csc_front.sv
// Front end: scans input bytes, tracks comment mode and builds output commands.
module csc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_ready,
	input  logic [7:0]      in_byte,
	output logic            push,
	output csc_pkg::cmd_t   cmd
);

	csc_pkg::mode_t mode_q, mode_d;
	logic           pend_q, pend_d;
	logic           take;

	assign take = in_valid && in_ready;
	assign push = take && (cmd.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= csc_pkg::MODE_NORMAL;
			pend_q <= 1'b0;
		end else if (take) begin
			mode_q <= mode_d;
			pend_q <= pend_d;
		end
	end

	// Next state
	always_comb begin
		mode_d = mode_q;
		pend_d = pend_q;
		case (mode_q)
			csc_pkg::MODE_SLASH: begin
				if (in_byte == csc_pkg::CH_STAR) begin
					pend_d = 1'b1;
					mode_d = csc_pkg::MODE_BLOCK;
				end else if (in_byte == csc_pkg::CH_SLASH) begin
					pend_d = 1'b1;
					mode_d = csc_pkg::MODE_LINE;
				end else begin
					mode_d = (in_byte == csc_pkg::CH_QUOTE) ? csc_pkg::MODE_QUOTE
						: csc_pkg::MODE_NORMAL;
				end
			end
			csc_pkg::MODE_QUOTE: begin
				if (in_byte == csc_pkg::CH_QUOTE)
					mode_d = csc_pkg::MODE_NORMAL;
			end
			csc_pkg::MODE_BLOCK: begin
				if (in_byte == csc_pkg::CH_STAR)
					mode_d = csc_pkg::MODE_STAR;
				else if (in_byte == csc_pkg::CH_NL)
					pend_d = 1'b1;
				else
					pend_d = 1'b0;
			end
			csc_pkg::MODE_STAR: begin
				if (in_byte == csc_pkg::CH_SLASH) begin
					mode_d = csc_pkg::MODE_NORMAL;
				end else begin
					pend_d = 1'b0;
					if (in_byte != csc_pkg::CH_STAR) begin
						mode_d = csc_pkg::MODE_BLOCK;
						if (in_byte == csc_pkg::CH_NL)
							pend_d = 1'b1;
					end
				end
			end
			csc_pkg::MODE_LINE: begin
				if (in_byte == csc_pkg::CH_NL) begin
					mode_d = csc_pkg::MODE_NORMAL;
				end else begin
					pend_d = 1'b0;
					if (in_byte == csc_pkg::CH_BSLASH)
						mode_d = csc_pkg::MODE_BSLASH;
				end
			end
			csc_pkg::MODE_BSLASH: begin
				mode_d = csc_pkg::MODE_LINE;
			end
			default: begin
				if (in_byte == csc_pkg::CH_SLASH)
					mode_d = csc_pkg::MODE_SLASH;
				else if (in_byte == csc_pkg::CH_QUOTE)
					mode_d = csc_pkg::MODE_QUOTE;
				else
					mode_d = csc_pkg::MODE_NORMAL;
			end
		endcase
	end

	// Output command
	always_comb begin
		cmd = '0;
		case (mode_q)
			csc_pkg::MODE_SLASH: begin
				if (!(in_byte inside {csc_pkg::CH_STAR, csc_pkg::CH_SLASH})) begin
					cmd = csc_pkg::push_byte(cmd, csc_pkg::CH_SLASH);
					cmd = csc_pkg::push_byte(cmd, in_byte);
				end
			end
			csc_pkg::MODE_QUOTE: begin
				cmd = csc_pkg::push_byte(cmd, in_byte);
			end
			csc_pkg::MODE_BLOCK: begin
				if (in_byte == csc_pkg::CH_NL) begin
					cmd = csc_pkg::push_byte(cmd, in_byte);
				end else if (in_byte != csc_pkg::CH_STAR) begin
					if (pend_q) begin
						cmd = csc_pkg::push_byte(cmd, csc_pkg::CH_SLASH);
						cmd = csc_pkg::push_byte(cmd, csc_pkg::CH_SLASH);
					end
					cmd = csc_pkg::push_byte(cmd, in_byte);
				end
			end
			csc_pkg::MODE_STAR: begin
				if (in_byte == csc_pkg::CH_SLASH) begin
					cmd = csc_pkg::push_byte(cmd, csc_pkg::CH_NL);
				end else begin
					if (pend_q) begin
						cmd = csc_pkg::push_byte(cmd, csc_pkg::CH_SLASH);
						cmd = csc_pkg::push_byte(cmd, csc_pkg::CH_SLASH);
					end
					cmd = csc_pkg::push_byte(cmd, csc_pkg::CH_STAR);
					if (in_byte != csc_pkg::CH_STAR)
						cmd = csc_pkg::push_byte(cmd, in_byte);
				end
			end
			csc_pkg::MODE_LINE: begin
				if (in_byte != csc_pkg::CH_NL && pend_q) begin
					cmd = csc_pkg::push_byte(cmd, csc_pkg::CH_SLASH);
					cmd = csc_pkg::push_byte(cmd, csc_pkg::CH_SLASH);
				end
				cmd = csc_pkg::push_byte(cmd, in_byte);
			end
			csc_pkg::MODE_BSLASH: begin
				cmd = csc_pkg::push_byte(cmd, in_byte);
			end
			default: begin
				if (in_byte != csc_pkg::CH_SLASH)
					cmd = csc_pkg::push_byte(cmd, in_byte);
			end
		endcase
	end

endmodule

### hw/rtl/csc_queue.sv
// Command queue between the scanning front end and the byte serializer.
module csc_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  csc_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output csc_pkg::cmd_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	csc_pkg::cmd_t         store_q [DEPTH];
	logic [AW-1:0]         wr_q, rd_q;
	logic [CW-1:0]         cnt_q;

	assign full      = (cnt_q == FULL_CNT);
	assign not_empty = (cnt_q != '0);
	assign head      = store_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			store_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### hw/rtl/csc_back.sv
// Back end: walks the head command and sends its bytes one transfer at a time.
module csc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  csc_pkg::cmd_t head,
	input  logic          out_ready,
	output logic          out_valid,
	output logic [7:0]    out_data,
	output logic          out_last,
	output logic          pop
);

	logic [1:0] idx_q;

	assign out_valid = head_valid;
	assign out_data  = head.bytes[idx_q];
	assign out_last  = ({1'b0, idx_q} == head.cnt - 3'd1);
	assign pop       = out_valid && out_ready && out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (out_valid && out_ready) begin
			// advance within the command, rewind after its last byte
			idx_q <= out_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

### verif/tb_top.sv
// Self-checking testbench for the block-to-line comment converter stream unit.
module tb_top;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} beat_t;

	// One directed row; when fixed is set, cnt/bytes hold the typed-in output,
	// lowest byte first.
	typedef struct packed {
		logic [7:0]  ch;
		logic        fixed;
		logic [2:0]  cnt;
		logic [31:0] bytes;
	} dir_row_t;

	localparam int N_DIR    = 28;
	localparam int N_RANDOM = 500;

	localparam dir_row_t DIR_TAB [N_DIR] = '{
		'{8'h00,              1'b1, 3'd1, 32'h0000_0000},
		'{8'hFF,              1'b1, 3'd1, 32'h0000_00FF},
		'{csc_pkg::CH_SLASH,  1'b1, 3'd0, 32'h0000_0000},
		'{8'h61,              1'b1, 3'd2, 32'h0000_612F},  // held slash comes back out
		'{csc_pkg::CH_SLASH,  1'b0, 3'd0, 32'h0},
		'{csc_pkg::CH_QUOTE,  1'b0, 3'd0, 32'h0},          // slash then quote opens a string
		'{csc_pkg::CH_SLASH,  1'b0, 3'd0, 32'h0},
		'{csc_pkg::CH_QUOTE,  1'b0, 3'd0, 32'h0},
		'{csc_pkg::CH_SLASH,  1'b1, 3'd0, 32'h0000_0000},
		'{csc_pkg::CH_STAR,   1'b1, 3'd0, 32'h0000_0000},
		'{csc_pkg::CH_NL,     1'b0, 3'd0, 32'h0},          // empty comment dropped
		'{8'h78,              1'b0, 3'd0, 32'h0},
		'{csc_pkg::CH_STAR,   1'b0, 3'd0, 32'h0},
		'{8'h79,              1'b0, 3'd0, 32'h0},          // star that does not close
		'{csc_pkg::CH_NL,     1'b0, 3'd0, 32'h0},
		'{csc_pkg::CH_STAR,   1'b0, 3'd0, 32'h0},
		'{csc_pkg::CH_STAR,   1'b0, 3'd0, 32'h0},          // prefix, then the held star
		'{csc_pkg::CH_NL,     1'b0, 3'd0, 32'h0},
		'{csc_pkg::CH_STAR,   1'b0, 3'd0, 32'h0},
		'{8'h71,              1'b0, 3'd0, 32'h0},          // four bytes out
		'{csc_pkg::CH_STAR,   1'b0, 3'd0, 32'h0},
		'{csc_pkg::CH_SLASH,  1'b0, 3'd0, 32'h0},          // close becomes newline
		'{csc_pkg::CH_SLASH,  1'b0, 3'd0, 32'h0},
		'{csc_pkg::CH_SLASH,  1'b0, 3'd0, 32'h0},
		'{csc_pkg::CH_BSLASH, 1'b0, 3'd0, 32'h0},          // prefix before the backslash
		'{csc_pkg::CH_NL,     1'b0, 3'd0, 32'h0},
		'{8'h7A,              1'b0, 3'd0, 32'h0},
		'{csc_pkg::CH_NL,     1'b0, 3'd0, 32'h0}
	};

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] in_byte
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // [7:0] out_byte
	logic       m_axis_tlast;           // last_of_run

	csc_pkg::mode_t scan_st      = csc_pkg::MODE_NORMAL;
	logic           prefix_armed = 1'b0;
	logic [7:0]     run_q [$];
	beat_t          expect_q [$];
	logic [7:0]     text_q [$];

	int err_count = 0;
	int sink_hold = 0;
	bit sink_calm = 1'b0;
	bit feed_calm = 1'b0;

	comment_style_converter_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void emit_prefix();
		if (prefix_armed) begin
			run_q.push_back(csc_pkg::CH_SLASH);
			run_q.push_back(csc_pkg::CH_SLASH);
			prefix_armed = 1'b0;
		end
	endfunction

	// Advance the converter state by one source byte; output bytes land in run_q.
	function automatic void convert_char(input logic [7:0] c);
		run_q.delete();
		case (scan_st)
			csc_pkg::MODE_SLASH: begin
				if (c == csc_pkg::CH_STAR) begin
					prefix_armed = 1'b1;
					scan_st = csc_pkg::MODE_BLOCK;
				end else if (c == csc_pkg::CH_SLASH) begin
					prefix_armed = 1'b1;
					scan_st = csc_pkg::MODE_LINE;
				end else begin
					run_q.push_back(csc_pkg::CH_SLASH);
					run_q.push_back(c);
					scan_st = (c == csc_pkg::CH_QUOTE) ? csc_pkg::MODE_QUOTE
						: csc_pkg::MODE_NORMAL;
				end
			end
			csc_pkg::MODE_QUOTE: begin
				run_q.push_back(c);
				if (c == csc_pkg::CH_QUOTE)
					scan_st = csc_pkg::MODE_NORMAL;
			end
			csc_pkg::MODE_BLOCK: begin
				if (c == csc_pkg::CH_STAR) begin
					scan_st = csc_pkg::MODE_STAR;
				end else if (c == csc_pkg::CH_NL) begin
					run_q.push_back(c);
					prefix_armed = 1'b1;
				end else begin
					emit_prefix();
					run_q.push_back(c);
				end
			end
			csc_pkg::MODE_STAR: begin
				if (c == csc_pkg::CH_SLASH) begin
					run_q.push_back(csc_pkg::CH_NL);
					scan_st = csc_pkg::MODE_NORMAL;
				end else begin
					emit_prefix();
					run_q.push_back(csc_pkg::CH_STAR);
					if (c != csc_pkg::CH_STAR) begin
						run_q.push_back(c);
						if (c == csc_pkg::CH_NL)
							prefix_armed = 1'b1;
						scan_st = csc_pkg::MODE_BLOCK;
					end
				end
			end
			csc_pkg::MODE_LINE: begin
				if (c == csc_pkg::CH_NL) begin
					run_q.push_back(c);
					scan_st = csc_pkg::MODE_NORMAL;
				end else begin
					emit_prefix();
					run_q.push_back(c);
					if (c == csc_pkg::CH_BSLASH)
						scan_st = csc_pkg::MODE_BSLASH;
				end
			end
			csc_pkg::MODE_BSLASH: begin
				run_q.push_back(c);
				scan_st = csc_pkg::MODE_LINE;
			end
			default: begin
				if (c == csc_pkg::CH_SLASH) begin
					scan_st = csc_pkg::MODE_SLASH;
				end else begin
					run_q.push_back(c);
					scan_st = (c == csc_pkg::CH_QUOTE) ? csc_pkg::MODE_QUOTE
						: csc_pkg::MODE_NORMAL;
				end
			end
		endcase
	endfunction

	// Present one byte, hold it until the transfer, then queue what it must produce.
	task automatic feed_char(input logic [7:0] c, input logic fixed, input logic [2:0] cnt,
			input logic [31:0] bytes);
		int gap;
		beat_t b;
		gap = feed_calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		do @(posedge clk); while (!s_axis_tready);
		convert_char(c);
		if (fixed) begin
			for (int k = 0; k < cnt; k++) begin
				b.data = bytes[8*k +: 8];
				b.last = (k == cnt - 1);
				expect_q.push_back(b);
			end
		end else begin
			for (int k = 0; k < run_q.size(); k++) begin
				b.data = run_q[k];
				b.last = (k == run_q.size() - 1);
				expect_q.push_back(b);
			end
		end
	endtask

	function automatic logic [7:0] pick_text_char();
		int r;
		r = $urandom_range(0, 15);
		case (r)
			0: return csc_pkg::CH_NL;
			1: return csc_pkg::CH_STAR;
			2: return csc_pkg::CH_SLASH;
			3: return csc_pkg::CH_QUOTE;
			4: return csc_pkg::CH_BSLASH;
			5: return 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(8'h61, 8'h7A));
		endcase
	endfunction

	// Append one fragment of source text: mostly well-formed comments and strings.
	task automatic make_snippet();
		int kind;
		int len;
		kind = $urandom_range(0, 9);
		len  = $urandom_range(0, 12);
		case (kind)
			0, 1: begin
				repeat (len + 1) text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
				if ($urandom_range(0, 1))
					text_q.push_back(csc_pkg::CH_NL);
			end
			2, 3, 4: begin
				text_q.push_back(csc_pkg::CH_SLASH);
				text_q.push_back(csc_pkg::CH_STAR);
				repeat (len) text_q.push_back(pick_text_char());
				// drop the closing mark now and then
				if ($urandom_range(0, 7) != 0) begin
					text_q.push_back(csc_pkg::CH_STAR);
					text_q.push_back(csc_pkg::CH_SLASH);
				end
			end
			5, 6: begin
				text_q.push_back(csc_pkg::CH_SLASH);
				text_q.push_back(csc_pkg::CH_SLASH);
				repeat (len) text_q.push_back(pick_text_char());
				text_q.push_back(csc_pkg::CH_NL);
			end
			7: begin
				text_q.push_back(csc_pkg::CH_QUOTE);
				repeat (len) text_q.push_back(pick_text_char());
				text_q.push_back(csc_pkg::CH_QUOTE);
			end
			default: begin
				repeat (len + 1) begin
					if ($urandom_range(0, 1))
						text_q.push_back(8'($urandom_range(0, 255)));
					else
						text_q.push_back(pick_text_char());
				end
			end
		endcase
	endtask

	task automatic check_beat();
		beat_t want;
		if (expect_q.size() == 0) begin
			$error("unexpected output transfer: out_byte %h last_of_run %b",
				m_axis_tdata, m_axis_tlast);
			err_count++;
		end else begin
			want = expect_q.pop_front();
			if (m_axis_tdata !== want.data) begin
				$error("out_byte mismatch: expected %h, got %h", want.data, m_axis_tdata);
				err_count++;
			end
			if (m_axis_tlast !== want.last) begin
				$error("last_of_run mismatch: expected %b, got %b", want.last, m_axis_tlast);
				err_count++;
			end
		end
	endtask

	// Output side: check every transfer, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_beat();
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				sink_calm = ~sink_calm;
			if (sink_hold > 0) begin
				m_axis_tready <= 1'b0;
				sink_hold--;
			end else begin
				m_axis_tready <= 1'b1;
				if (!sink_calm)
					sink_hold = pick_gap();
			end
		end
	end

	initial begin
		int n_sent;
		int wait_n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			feed_char(DIR_TAB[i].ch, DIR_TAB[i].fixed, DIR_TAB[i].cnt, DIR_TAB[i].bytes);

		n_sent = 0;
		while (n_sent < N_RANDOM) begin
			if (text_q.size() == 0)
				make_snippet();
			// hold off the sender until the output side has caught up
			if (n_sent == N_RANDOM / 2) begin
				s_axis_tvalid <= 1'b0;
				do @(posedge clk); while (expect_q.size() != 0);
			end
			if ($urandom_range(0, 39) == 0)
				feed_calm = ~feed_calm;
			feed_char(text_q.pop_front(), 1'b0, 3'd0, 32'd0);
			n_sent++;
		end

		s_axis_tvalid <= 1'b0;
		wait_n = 0;
		while (expect_q.size() != 0 && wait_n < 20000) begin
			@(posedge clk);
			wait_n++;
		end
		repeat (8) @(posedge clk);
		if (expect_q.size() != 0) begin
			$error("%0d expected output transfers never arrived", expect_q.size());
			err_count++;
		end

		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
